/* design/dfs_rc_pkg.sv */
package dfs_rc_pkg;

  localparam int MAX_NODES = 64;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int FUNC_W = 2;
  localparam int CFG_W  = 7;
  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_TRAVERSE = 2'd1,
    FUNC_CLEAR    = 2'd2
  } func_t;

  typedef enum logic [0:0] {
    CFG_MODE       = 1'b0,
    CFG_NODE_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_SCAN,
    S_POP
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [CNT_W-1:0]  next_col;
  } stk_entry_t;

endpackage

/* design/dfs_rc_in_if.sv */
interface dfs_rc_in_if;
  logic                           valid;
  logic                           ready;
  logic [dfs_rc_pkg::FUNC_W-1:0]  func;
  logic [dfs_rc_pkg::NODE_W-1:0]  row_index;
  logic [dfs_rc_pkg::NODE_W-1:0]  col_index;
  logic                           edge_present;
  logic [dfs_rc_pkg::NODE_W-1:0]  start_index;

  modport source (output valid, func, row_index, col_index, edge_present, start_index,
                  input ready);
  modport sink (input valid, func, row_index, col_index, edge_present, start_index,
                output ready);
endinterface

/* design/dfs_rc_out_if.sv */
interface dfs_rc_out_if;
  logic                           valid;
  logic                           ready;
  logic [dfs_rc_pkg::NODE_W-1:0]  node_out;
  logic [dfs_rc_pkg::CNT_W-1:0]   finished_count;
  logic                           last_result;

  modport source (output valid, node_out, finished_count, last_result, input ready);
  modport sink (input valid, node_out, finished_count, last_result, output ready);
endinterface

/* design/iterative_dfs_reach_count_unit.sv */
// channel   | dir | word
// in_ch     | in  | func, row_index, col_index, edge_present, start_index
// out_ch    | out | node_out, finished_count, last_result
// cfg_*     | in  | write enable, register index, write data
//
// Load: row read, then row write. Clear: done in the idle state.
// Traverse: a start outside the graph ends in the start state; each step of a walk
// waits on the registered read of the adjacency memory or the stack memory.
// Reset: synchronous, no clearing pass; row and color valid bits clear at once.
// A result held by a stalled out_ch holds the walk at the next finish that emits a word.
module iterative_dfs_reach_count_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [dfs_rc_pkg::CFG_W-1:0] cfg_wdata,
  dfs_rc_in_if.sink                    in_ch,
  dfs_rc_out_if.source                 out_ch
);

  localparam int N  = dfs_rc_pkg::MAX_NODES;
  localparam int AW = dfs_rc_pkg::NODE_AW;
  localparam int NW = dfs_rc_pkg::NODE_W;
  localparam int CW = dfs_rc_pkg::CNT_W;

  dfs_rc_pkg::state_t state_r, state_nxt;

  logic          mode_r;
  logic [CW-1:0] ncount_r;
  logic [CW-1:0] n_eff;

  logic [NW-1:0] cur_node_r, cur_node_nxt;
  logic [CW-1:0] cur_k_r, cur_k_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] tally_r, tally_nxt;
  logic [NW-1:0] start_r, start_nxt;
  logic [NW-1:0] ld_row_r, ld_row_nxt;
  logic [NW-1:0] ld_col_r, ld_col_nxt;
  logic          ld_edge_r, ld_edge_nxt;
  logic [N-1:0]  nonwhite_r, nonwhite_nxt;
  logic [N-1:0]  adj_vld_r, adj_vld_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [NW-1:0] out_node_r, out_node_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_free;

  logic [N-1:0]  adj_mem [N];
  logic [N-1:0]  adj_q;
  logic [AW-1:0] adj_raddr;
  logic          adj_we;
  logic [AW-1:0] adj_waddr;
  logic [N-1:0]  adj_wdata;

  dfs_rc_pkg::stk_entry_t stk_mem [N];
  dfs_rc_pkg::stk_entry_t stk_q;
  dfs_rc_pkg::stk_entry_t stk_wdata;
  logic [AW-1:0] stk_raddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;

  logic [AW-1:0] cur_idx;
  logic [N-1:0]  row_eff;
  logic [N-1:0]  avail;
  logic          found;
  logic [CW-1:0] k_hit;
  logic [N-1:0]  ld_row_data;
  logic          in_take;

  assign cur_idx = cur_node_r[AW-1:0];
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == dfs_rc_pkg::S_IDLE);
  assign in_take = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.node_out       = out_node_r;
  assign out_ch.finished_count = out_count_r;
  assign out_ch.last_result    = out_last_r;

  always_comb begin
    if (ncount_r > CW'(N)) begin
      n_eff = CW'(N);
    end else if (ncount_r == '0) begin
      n_eff = CW'(1);
    end else begin
      n_eff = ncount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      ncount_r <= CW'(64);
    end else if (cfg_we) begin
      unique case (dfs_rc_pkg::cfg_idx_t'(cfg_index))
        dfs_rc_pkg::CFG_MODE:       mode_r   <= cfg_wdata[0];
        dfs_rc_pkg::CFG_NODE_COUNT: ncount_r <= cfg_wdata[CW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  always_comb begin
    row_eff = adj_vld_r[cur_idx] ? adj_q : '0;
    for (int i = 0; i < N; i++) begin
      avail[i] = row_eff[i] && !nonwhite_r[i] && (AW'(i) != cur_idx) &&
                 (CW'(i) >= cur_k_r) && (CW'(i) < n_eff);
    end
    found = |avail;
    k_hit = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (avail[i]) begin
        k_hit = CW'(i);
      end
    end
  end

  always_comb begin
    ld_row_data = adj_vld_r[ld_row_r[AW-1:0]] ? adj_q : '0;
    ld_row_data[ld_col_r[AW-1:0]] = ld_edge_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_node_nxt  = cur_node_r;
    cur_k_nxt     = cur_k_r;
    depth_nxt     = depth_r;
    tally_nxt     = tally_r;
    start_nxt     = start_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    ld_edge_nxt   = ld_edge_r;
    nonwhite_nxt  = nonwhite_r;
    adj_vld_nxt   = adj_vld_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_node_nxt  = out_node_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    adj_raddr     = cur_idx;
    adj_we        = 1'b0;
    adj_waddr     = ld_row_r[AW-1:0];
    adj_wdata     = ld_row_data;
    stk_raddr     = AW'(depth_r - CW'(2));
    stk_we        = 1'b0;
    stk_waddr     = AW'(depth_r - CW'(1));
    stk_wdata.node     = cur_node_r;
    stk_wdata.next_col = k_hit + CW'(1);

    unique case (state_r)
      dfs_rc_pkg::S_IDLE: begin
        if (in_take) begin
          case (in_ch.func)
            dfs_rc_pkg::FUNC_LOAD: begin
              if ((CW'(in_ch.row_index) < CW'(N)) && (CW'(in_ch.col_index) < CW'(N))) begin
                adj_raddr   = in_ch.row_index[AW-1:0];
                ld_row_nxt  = in_ch.row_index;
                ld_col_nxt  = in_ch.col_index;
                ld_edge_nxt = in_ch.edge_present;
                state_nxt   = dfs_rc_pkg::S_LOAD;
              end
            end
            dfs_rc_pkg::FUNC_TRAVERSE: begin
              start_nxt = in_ch.start_index;
              state_nxt = dfs_rc_pkg::S_START;
            end
            dfs_rc_pkg::FUNC_CLEAR: begin
              nonwhite_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      dfs_rc_pkg::S_LOAD: begin
        adj_we = 1'b1;
        adj_vld_nxt[ld_row_r[AW-1:0]] = 1'b1;
        state_nxt = dfs_rc_pkg::S_IDLE;
      end

      dfs_rc_pkg::S_START: begin
        tally_nxt = '0;
        depth_nxt = '0;
        if (CW'(start_r) < n_eff) begin
          cur_node_nxt = start_r;
          cur_k_nxt    = '0;
          depth_nxt    = CW'(1);
          adj_raddr    = start_r[AW-1:0];
          state_nxt    = dfs_rc_pkg::S_SCAN;
        end else if (!mode_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = '0;
            out_count_nxt = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = dfs_rc_pkg::S_IDLE;
          end
        end else begin
          state_nxt = dfs_rc_pkg::S_IDLE;
        end
      end

      dfs_rc_pkg::S_SCAN: begin
        nonwhite_nxt[cur_idx] = 1'b1;
        if (found) begin
          if (depth_r < CW'(N)) begin
            stk_we       = 1'b1;
            cur_node_nxt = NW'(k_hit);
            cur_k_nxt    = '0;
            depth_nxt    = depth_r + CW'(1);
            adj_raddr    = k_hit[AW-1:0];
          end else begin
            cur_k_nxt = k_hit + CW'(1);
          end
        end else if (out_free || (!mode_r && (depth_r != CW'(1)))) begin
          tally_nxt = tally_r + CW'(1);
          depth_nxt = depth_r - CW'(1);
          if (mode_r) begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = cur_node_r;
            out_count_nxt = '0;
            out_last_nxt  = (depth_r == CW'(1));
          end else if (depth_r == CW'(1)) begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = '0;
            out_count_nxt = tally_r + CW'(1);
            out_last_nxt  = 1'b1;
          end
          if (depth_r == CW'(1)) begin
            state_nxt = dfs_rc_pkg::S_IDLE;
          end else begin
            state_nxt = dfs_rc_pkg::S_POP;
          end
        end
      end

      dfs_rc_pkg::S_POP: begin
        cur_node_nxt = stk_q.node;
        cur_k_nxt    = stk_q.next_col;
        adj_raddr    = stk_q.node[AW-1:0];
        state_nxt    = dfs_rc_pkg::S_SCAN;
      end

      default: begin
        state_nxt = dfs_rc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfs_rc_pkg::S_IDLE;
      depth_r     <= '0;
      tally_r     <= '0;
      nonwhite_r  <= '0;
      adj_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      tally_r     <= tally_nxt;
      nonwhite_r  <= nonwhite_nxt;
      adj_vld_r   <= adj_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_node_r  <= cur_node_nxt;
    cur_k_r     <= cur_k_nxt;
    start_r     <= start_nxt;
    ld_row_r    <= ld_row_nxt;
    ld_col_r    <= ld_col_nxt;
    ld_edge_r   <= ld_edge_nxt;
    out_node_r  <= out_node_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfs_rc_pkg::S_IDLE) |-> (depth_r == '0))
    else $error("stack not empty in idle");

  a_scan_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfs_rc_pkg::S_SCAN) |-> ((depth_r != '0) && (depth_r <= CW'(N))))
    else $error("stack depth out of range during walk");

  a_pop_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfs_rc_pkg::S_POP) |-> ($past(state_r) == dfs_rc_pkg::S_SCAN))
    else $error("pop without finish");

  a_scan_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfs_rc_pkg::S_SCAN) |=> nonwhite_r[$past(cur_idx)])
    else $error("scanned node left white");

endmodule

/* tb/sv/iterative_dfs_reach_count_unit_test.sv */
`timescale 1ns / 1ps

module iterative_dfs_reach_count_unit_test;

  localparam int MAX_NODES = dfs_rc_pkg::MAX_NODES;
  localparam int NODE_W    = dfs_rc_pkg::NODE_W;
  localparam int CNT_W     = dfs_rc_pkg::CNT_W;
  localparam int FUNC_W    = dfs_rc_pkg::FUNC_W;
  localparam int CFG_W     = dfs_rc_pkg::CFG_W;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 35;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GREY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic [CNT_W-1:0]  count;
    logic              last;
  } reach_word_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  dfs_rc_in_if  in_ch ();
  dfs_rc_out_if out_ch ();

  iterative_dfs_reach_count_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [MAX_NODES-1:0] graph_rows [MAX_NODES];
  logic [1:0]           walk_shade [MAX_NODES];
  logic                 finish_order_mode;
  logic [CFG_W-1:0]     node_count_reg;
  reach_word_t          expected_words [$];

  int fail_count   = 0;
  int words_sent   = 0;
  int traversals   = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int hold_left    = 0;
  bit steady       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold off on request, otherwise stall at random unless steady
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    reach_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: node_out %0d finished_count %0d last_result %0d",
               out_ch.node_out, out_ch.finished_count, out_ch.last_result);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_ch.node_out !== want.node) begin
          $error("node_out expected %0d actual %0d", want.node, out_ch.node_out);
          fail_count++;
        end
        if (out_ch.finished_count !== want.count) begin
          $error("finished_count expected %0d actual %0d", want.count,
                 out_ch.finished_count);
          fail_count++;
        end
        if (out_ch.last_result !== want.last) begin
          $error("last_result expected %0d actual %0d", want.last, out_ch.last_result);
          fail_count++;
        end
      end
    end
  end

  function automatic int live_nodes();
    int n;
    n = node_count_reg;
    if (n > MAX_NODES) n = MAX_NODES;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic void predict_walk(input int start);
    int          n;
    int          depth;
    int          top;
    int          cur;
    int          k;
    int          done;
    int          trail_node [MAX_NODES];
    int          trail_col [MAX_NODES];
    reach_word_t finished [$];
    reach_word_t w;
    n = live_nodes();
    depth = 0;
    done = 0;
    traversals++;
    if (start < n) begin
      trail_node[0] = start;
      trail_col[0] = 0;
      depth = 1;
    end
    while (depth > 0) begin
      top = depth - 1;
      cur = trail_node[top];
      k = trail_col[top];
      walk_shade[cur] = COLOR_GREY;
      while (k < n && !(graph_rows[cur][k] && walk_shade[k] == COLOR_WHITE)) k++;
      if (k >= n) begin
        w.node = cur[NODE_W-1:0];
        w.count = '0;
        w.last = 1'b0;
        finished = {finished, w};
        done++;
        walk_shade[cur] = COLOR_BLACK;
        depth--;
      end else begin
        trail_col[top] = k + 1;
        if (depth < MAX_NODES) begin
          trail_node[depth] = k;
          trail_col[depth] = 0;
          depth++;
        end
      end
    end
    if (finish_order_mode) begin
      if (finished.size() > 0) finished[finished.size()-1].last = 1'b1;
      expected_words = {expected_words, finished};
    end else begin
      w.node = '0;
      w.count = done[CNT_W-1:0];
      w.last = 1'b1;
      expected_words = {expected_words, w};
    end
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input int row, input int col,
                           input bit edge_bit, input int start);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.row_index    <= row[NODE_W-1:0];
    in_ch.col_index    <= col[NODE_W-1:0];
    in_ch.edge_present <= edge_bit;
    in_ch.start_index  <= start[NODE_W-1:0];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    case (f)
      dfs_rc_pkg::FUNC_LOAD:     graph_rows[row][col] = edge_bit;
      dfs_rc_pkg::FUNC_TRAVERSE: predict_walk(start);
      dfs_rc_pkg::FUNC_CLEAR:    foreach (walk_shade[i]) walk_shade[i] = COLOR_WHITE;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dfs_rc_pkg::cfg_idx_t idx, input int value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dfs_rc_pkg::CFG_MODE) finish_order_mode = value[0];
    else node_count_reg = value[CFG_W-1:0];
  endtask

  task automatic test_corner_cases();
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 0);
    send_word(dfs_rc_pkg::FUNC_LOAD, 0, 63, 1'b1, 63);
    send_word(dfs_rc_pkg::FUNC_LOAD, 63, 63, 1'b1, 0);
    // start node already black: entered and counted again
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 63, 0, 1'b1, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 63, 1'b0, 0);
    send_word(FUNC_UNUSED, 63, 63, 1'b1, 63);
    send_word(dfs_rc_pkg::FUNC_CLEAR, 42, 21, 1'b1, 42);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 21, 42, 1'b0, 63);
    send_word(dfs_rc_pkg::FUNC_LOAD, 63, 63, 1'b0, 21);
    send_word(dfs_rc_pkg::FUNC_LOAD, 42, 21, 1'b1, 0);
    send_word(dfs_rc_pkg::FUNC_LOAD, 21, 42, 1'b1, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 21);
    write_reg(dfs_rc_pkg::CFG_NODE_COUNT, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 5);
    write_reg(dfs_rc_pkg::CFG_MODE, 1);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 5);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 0);
    write_reg(dfs_rc_pkg::CFG_NODE_COUNT, 127);
    send_word(dfs_rc_pkg::FUNC_CLEAR, 0, 0, 1'b0, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 21);
    // edge to 42 is kept but lies past the node limit
    write_reg(dfs_rc_pkg::CFG_NODE_COUNT, 22);
    send_word(dfs_rc_pkg::FUNC_CLEAR, 0, 0, 1'b0, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 21);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, 42);
  endtask

  task automatic test_small_graphs(input int phases);
    int lim;
    int roll;
    int n;
    int start;
    for (int p = 0; p < phases; p++) begin
      roll = $urandom_range(9);
      if (roll == 0) lim = $urandom_range(65, 127);
      else if (roll == 1) lim = $urandom_range(13, MAX_NODES);
      else lim = $urandom_range(2, 12);
      write_reg(dfs_rc_pkg::CFG_NODE_COUNT, lim);
      write_reg(dfs_rc_pkg::CFG_MODE, $urandom_range(1));
      n = live_nodes();
      steady = (p == 3);
      repeat ($urandom_range(10, 24)) begin
        roll = $urandom_range(99);
        if (roll < 8)
          send_word(dfs_rc_pkg::FUNC_LOAD, $urandom_range(63), $urandom_range(63),
                    1'($urandom_range(1)), $urandom_range(63));
        else if (roll < 11)
          send_word(FUNC_UNUSED, $urandom_range(63), $urandom_range(63),
                    1'($urandom_range(1)), $urandom_range(63));
        else
          send_word(dfs_rc_pkg::FUNC_LOAD, $urandom_range(n - 1), $urandom_range(n - 1),
                    $urandom_range(3) != 0, $urandom_range(63));
      end
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(1))
          send_word(dfs_rc_pkg::FUNC_CLEAR, $urandom_range(63), $urandom_range(63),
                    1'($urandom_range(1)), $urandom_range(63));
        start = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(n - 1);
        send_word(dfs_rc_pkg::FUNC_TRAVERSE, $urandom_range(63), $urandom_range(63),
                  1'($urandom_range(1)), start);
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_deep_chain();
    int order [MAX_NODES];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = MAX_NODES - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    write_reg(dfs_rc_pkg::CFG_NODE_COUNT, MAX_NODES);
    write_reg(dfs_rc_pkg::CFG_MODE, 1);
    steady = 1'b1;
    for (int i = 0; i < MAX_NODES - 1; i++)
      send_word(dfs_rc_pkg::FUNC_LOAD, order[i], order[i+1], 1'b1, $urandom_range(63));
    steady = 1'b0;
    send_word(dfs_rc_pkg::FUNC_CLEAR, $urandom_range(63), $urandom_range(63), 1'b0, 0);
    // stall the result side so the walk backs up into the input
    hold_left = HOLD_CYCLES;
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, $urandom_range(63), $urandom_range(63), 1'b1,
              order[0]);
    send_word(dfs_rc_pkg::FUNC_CLEAR, $urandom_range(63), $urandom_range(63), 1'b1, 63);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, order[$urandom_range(MAX_NODES - 1)]);
    write_reg(dfs_rc_pkg::CFG_MODE, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, order[0]);
    send_word(dfs_rc_pkg::FUNC_CLEAR, 0, 0, 1'b0, 0);
    send_word(dfs_rc_pkg::FUNC_TRAVERSE, 0, 0, 1'b0, order[0]);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = dfs_rc_pkg::CFG_MODE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = dfs_rc_pkg::FUNC_LOAD;
    in_ch.row_index    = '0;
    in_ch.col_index    = '0;
    in_ch.edge_present = 1'b0;
    in_ch.start_index  = '0;
    finish_order_mode  = 1'b0;
    node_count_reg     = CFG_W'(MAX_NODES);
    foreach (graph_rows[i]) graph_rows[i] = '0;
    foreach (walk_shade[i]) walk_shade[i] = COLOR_WHITE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_small_graphs(13);
    test_deep_chain();
    settle();
    $display("run covered %0d input words and %0d walks, %0d result words checked",
             words_sent, traversals, results_seen);
    $display("node limits 1 to 64 and saturated, both result modes, 64-deep walk under hold-off");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
design/dfs_rc_pkg.sv
design/dfs_rc_in_if.sv
design/dfs_rc_out_if.sv
design/iterative_dfs_reach_count_unit.sv
tb/sv/iterative_dfs_reach_count_unit_test.sv
